[rtl/core/rmf_pkg.sv]
package rmf_pkg;

    // Fixed field widths
    localparam int CFG_W = 10;
    localparam int DIV_W = 10;

    // Fragment store geometry
    localparam int FRAGMENT_SLOTS = 16;
    localparam int FRAGMENT_BYTES = 512;

    // One input item
    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] session_id;
        logic [15:0] total_duration;
        logic [15:0] passed_duration;
        logic [7:0]  section_type;
        logic [9:0]  record_bytes;
        logic [15:0] record_total;
        logic [7:0]  data_byte;
        logic [4:0]  read_fragment;
        logic [8:0]  read_offset;
    } t_item;

    // One result item
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic [9:0] read_length;
        logic [4:0] fragment_total;
    } t_result;

    // Actions
    localparam logic [2:0] ACT_CLEAR    = 3'd0;
    localparam logic [2:0] ACT_START    = 3'd1;
    localparam logic [2:0] ACT_SECTION  = 3'd2;
    localparam logic [2:0] ACT_RECORD   = 3'd3;
    localparam logic [2:0] ACT_FINALIZE = 3'd4;
    localparam logic [2:0] ACT_READ     = 3'd5;

    // Status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_CAPACITY   = 3'd1;
    localparam logic [2:0] ST_NO_SLOT    = 3'd2;
    localparam logic [2:0] ST_SESSION    = 3'd3;
    localparam logic [2:0] ST_NO_SECTION = 3'd4;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd5;

    // Record type bytes of the session preamble
    localparam logic [7:0] REC_COUNT    = 8'h06;
    localparam logic [7:0] REC_DURATION = 8'h01;
    localparam logic [7:0] REC_PASSED   = 8'h02;

    // Datapath operations
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_CLEAR      = 4'd1;
    localparam logic [3:0] OP_SWEEP      = 4'd2;
    localparam logic [3:0] OP_BEGIN_FRAG = 4'd3;
    localparam logic [3:0] OP_PUT        = 4'd4;
    localparam logic [3:0] OP_OPEN       = 4'd5;
    localparam logic [3:0] OP_REC        = 4'd6;
    localparam logic [3:0] OP_DIV        = 4'd7;
    localparam logic [3:0] OP_SET_CHUNK  = 4'd8;
    localparam logic [3:0] OP_FINAL      = 4'd9;
    localparam logic [3:0] OP_READ       = 4'd10;

    // Byte sources for OP_PUT
    localparam logic [3:0] PB_NEXT_HI = 4'd0;
    localparam logic [3:0] PB_NEXT_LO = 4'd1;
    localparam logic [3:0] PB_SES_HI  = 4'd2;
    localparam logic [3:0] PB_SES_LO  = 4'd3;
    localparam logic [3:0] PB_COUNT   = 4'd4;
    localparam logic [3:0] PB_ZERO    = 4'd5;
    localparam logic [3:0] PB_DUR_REC = 4'd6;
    localparam logic [3:0] PB_DUR_HI  = 4'd7;
    localparam logic [3:0] PB_DUR_LO  = 4'd8;
    localparam logic [3:0] PB_PAS_REC = 4'd9;
    localparam logic [3:0] PB_PAS_HI  = 4'd10;
    localparam logic [3:0] PB_PAS_LO  = 4'd11;
    localparam logic [3:0] PB_TYPE    = 4'd12;
    localparam logic [3:0] PB_N_HI    = 4'd13;
    localparam logic [3:0] PB_N_LO    = 4'd14;

    // Controller to datapath
    typedef struct packed {
        logic [3:0] op;
        logic [3:0] pb;
        logic       use_item_ses;
        logic       close;
        logic       load_out;
        logic [2:0] status;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] action;
        logic       cap_lt4;
        logic       next_full;
        logic       item_size_zero;
        logic       item_cap_short;
        logic       item_total_zero;
        logic       chunk_cap_fail;
        logic       started;
        logic       ses_mismatch;
        logic       room_short;
        logic       chunk_open;
        logic       rec_last;
        logic       chunk_more;
        logic       sect_more;
        logic       div_busy;
        logic       sweep_last;
        logic       out_full;
    } t_dp_stat;

endpackage

[rtl/core/rmf_ram.sv]
module rmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rmf_div.sv]
module rmf_div #(
    parameter int W = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic [W-1:0] o_quo
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [W:0]       w_shift;
    logic [W:0]       w_trial;
    logic             w_fits;

    // One quotient bit per cycle, restoring
    assign w_shift = {r_rem, r_quo[W-1]};
    assign w_trial = w_shift - {1'b0, r_den};
    assign w_fits  = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_trial[W-1:0] : w_shift[W-1:0];
            r_quo <= {r_quo[W-2:0], w_fits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

[rtl/core/rmf_ctrl.sv]
module rmf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rmf_pkg::t_dp_stat i_stat,
    output rmf_pkg::t_cmd     o_cmd,
    output logic              o_in_ready
);
    import rmf_pkg::*;

    localparam logic [3:0] S_SWEEP0 = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_SWEEP  = 4'd3;
    localparam logic [3:0] S_PUTS   = 4'd4;
    localparam logic [3:0] S_BC     = 4'd5;
    localparam logic [3:0] S_BF     = 4'd6;
    localparam logic [3:0] S_DIVGO  = 4'd7;
    localparam logic [3:0] S_DIVW   = 4'd8;
    localparam logic [3:0] S_CHDR   = 4'd9;
    localparam logic [3:0] S_RD     = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [2:0] r_status, n_status;

    // Byte order of the session preamble
    function automatic logic [3:0] start_byte(input logic [3:0] step);
        logic [3:0] pb;
        case (step)
            4'd0:    pb = PB_NEXT_HI;
            4'd1:    pb = PB_NEXT_LO;
            4'd2:    pb = PB_SES_HI;
            4'd3:    pb = PB_SES_LO;
            4'd4:    pb = PB_COUNT;
            4'd5:    pb = PB_ZERO;
            4'd6:    pb = PB_DUR_REC;
            4'd7:    pb = PB_DUR_HI;
            4'd8:    pb = PB_DUR_LO;
            4'd9:    pb = PB_PAS_REC;
            4'd10:   pb = PB_PAS_HI;
            default: pb = PB_PAS_LO;
        endcase
        return pb;
    endfunction

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_status = r_status;
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.status = r_status;
        case (r_state)
            S_SWEEP0: begin
                o_cmd.op = OP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_status = ST_OK;
                n_state  = S_DONE;
                case (i_stat.action)
                    ACT_CLEAR: begin
                        o_cmd.op = OP_CLEAR;
                        n_state  = S_SWEEP;
                    end
                    ACT_START: begin
                        o_cmd.close = 1'b1;
                        if (i_stat.cap_lt4) begin
                            n_status = ST_CAPACITY;
                        end else if (i_stat.next_full) begin
                            n_status = ST_NO_SLOT;
                        end else begin
                            o_cmd.op           = OP_BEGIN_FRAG;
                            o_cmd.use_item_ses = 1'b1;
                            n_step             = '0;
                            n_state            = S_PUTS;
                        end
                    end
                    ACT_SECTION: begin
                        o_cmd.close = 1'b1;
                        if (i_stat.item_size_zero) begin
                            n_status = ST_BAD_SIZE;
                        end else if (i_stat.item_cap_short) begin
                            n_status = ST_CAPACITY;
                        end else if (!i_stat.item_total_zero) begin
                            // the open resets the section counters itself
                            o_cmd.op    = OP_OPEN;
                            o_cmd.close = 1'b0;
                            n_state     = S_BC;
                        end
                    end
                    ACT_RECORD: begin
                        if (!i_stat.chunk_open) begin
                            n_status = ST_NO_SECTION;
                        end else begin
                            o_cmd.op = OP_REC;
                            if (i_stat.rec_last && !i_stat.chunk_more && i_stat.sect_more) begin
                                n_state = S_BC;
                            end
                        end
                    end
                    ACT_FINALIZE: begin
                        o_cmd.op = OP_FINAL;
                    end
                    ACT_READ: begin
                        o_cmd.op = OP_READ;
                        n_state  = S_RD;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SWEEP: begin
                o_cmd.op = OP_SWEEP;
                if (i_stat.sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_PUTS: begin
                o_cmd.op = OP_PUT;
                o_cmd.pb = start_byte(r_step);
                n_step   = r_step + 1'b1;
                if (r_step == 4'd11) begin
                    n_state = S_DONE;
                end
            end
            // Checks that precede every chunk
            S_BC: begin
                n_state = S_DONE;
                if (i_stat.chunk_cap_fail) begin
                    n_status    = ST_CAPACITY;
                    o_cmd.close = 1'b1;
                end else if (!i_stat.started || i_stat.ses_mismatch) begin
                    n_status    = ST_SESSION;
                    o_cmd.close = 1'b1;
                end else if (i_stat.room_short) begin
                    if (i_stat.next_full) begin
                        n_status    = ST_NO_SLOT;
                        o_cmd.close = 1'b1;
                    end else begin
                        o_cmd.op = OP_BEGIN_FRAG;
                        n_step   = '0;
                        n_state  = S_BF;
                    end
                end else begin
                    n_state = S_DIVGO;
                end
            end
            S_BF: begin
                o_cmd.op = OP_PUT;
                o_cmd.pb = start_byte(r_step);
                n_step   = r_step + 1'b1;
                if (r_step == 4'd3) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                o_cmd.op = OP_DIV;
                n_state  = S_DIVW;
            end
            S_DIVW: begin
                if (!i_stat.div_busy) begin
                    o_cmd.op = OP_SET_CHUNK;
                    n_step   = '0;
                    n_state  = S_CHDR;
                end
            end
            // Chunk header: type, count high, count low
            S_CHDR: begin
                o_cmd.op = OP_PUT;
                case (r_step)
                    4'd0:    o_cmd.pb = PB_TYPE;
                    4'd1:    o_cmd.pb = PB_N_HI;
                    default: o_cmd.pb = PB_N_LO;
                endcase
                n_step = r_step + 1'b1;
                if (r_step == 4'd2) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP0;
            r_step   <= '0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

[rtl/core/rmf_dp.sv]
module rmf_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  rmf_pkg::t_item       i_item,
    input  logic [9:0]           i_capacity,
    input  rmf_pkg::t_cmd        i_cmd,
    output rmf_pkg::t_dp_stat    o_stat,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output rmf_pkg::t_result     o_out
);
    import rmf_pkg::*;

    localparam int CW    = (FRAGMENT_SLOTS > 1) ? $clog2(FRAGMENT_SLOTS) : 1;
    localparam int LW    = $clog2(FRAGMENT_BYTES + 1);
    localparam int DEPTH = FRAGMENT_SLOTS * FRAGMENT_BYTES;
    localparam int AW    = $clog2(DEPTH);

    t_item          r_item;
    t_result        r_out;
    logic           r_out_valid;
    logic [CW-1:0]  r_cur;
    logic           r_started;
    logic [LW-1:0]  r_cur_len;
    logic [LW-1:0]  r_len_tbl [FRAGMENT_SLOTS];
    logic [15:0]    r_cur_session;
    logic [LW-1:0]  r_cpos;
    logic [7:0]     r_open_type;
    logic [9:0]     r_open_size;
    logic [15:0]    r_open_session;
    logic [15:0]    r_sec;
    logic [15:0]    r_chunk;
    logic [9:0]     r_bytes;
    logic [AW-1:0]  r_sweep;

    logic [CW:0]        w_total;
    logic [15:0]        w_len16;
    logic [15:0]        w_cap16;
    logic [15:0]        w_room;
    logic               w_put_ok;
    logic [7:0]         w_pbyte;
    logic [CW-1:0]      w_rd_idx;
    logic               w_frag_ok;
    logic               w_off_ok;
    logic [AW-1:0]      w_cur_base;
    logic [AW-1:0]      w_rd_addr;
    logic               w_we;
    logic               w_re;
    logic [AW-1:0]      w_addr;
    logic [7:0]         w_wdata;
    logic [7:0]         w_q;
    logic               w_div_busy;
    logic [DIV_W-1:0]   w_quo;
    logic [15:0]        w_n;
    logic               w_rec_last;
    logic               w_chunk_more;

    // Fragment count; also the index of the next fragment to begin
    assign w_total = r_started ? ({1'b0, r_cur} + 1'b1) : '0;

    // Space left in the current fragment
    assign w_len16 = 16'(r_cur_len);
    assign w_cap16 = 16'(i_capacity);
    assign w_room  = (w_len16 >= w_cap16) ? 16'd0 : (w_cap16 - w_len16);

    assign w_put_ok     = (r_cur_len < LW'(FRAGMENT_BYTES));
    assign w_rec_last   = (r_bytes <= 10'd1);
    assign w_chunk_more = (r_chunk > 16'd1);
    assign w_n          = (r_sec < 16'(w_quo)) ? r_sec : 16'(w_quo);

    // Read position
    assign w_rd_idx   = CW'(r_item.read_fragment);
    assign w_frag_ok  = (int'(r_item.read_fragment) < FRAGMENT_SLOTS);
    assign w_off_ok   = (int'(r_item.read_offset) < FRAGMENT_BYTES);
    assign w_cur_base = AW'(r_cur) * AW'(FRAGMENT_BYTES);
    assign w_rd_addr  = AW'(w_rd_idx) * AW'(FRAGMENT_BYTES) + AW'(r_item.read_offset);

    // Byte to append
    always_comb begin
        case (i_cmd.pb)
            PB_NEXT_HI: w_pbyte = 8'(16'(r_cur) >> 8);
            PB_NEXT_LO: w_pbyte = 8'(r_cur);
            PB_SES_HI:  w_pbyte = r_cur_session[15:8];
            PB_SES_LO:  w_pbyte = r_cur_session[7:0];
            PB_COUNT:   w_pbyte = REC_COUNT;
            PB_ZERO:    w_pbyte = 8'd0;
            PB_DUR_REC: w_pbyte = REC_DURATION;
            PB_DUR_HI:  w_pbyte = r_item.total_duration[15:8];
            PB_DUR_LO:  w_pbyte = r_item.total_duration[7:0];
            PB_PAS_REC: w_pbyte = REC_PASSED;
            PB_PAS_HI:  w_pbyte = r_item.passed_duration[15:8];
            PB_PAS_LO:  w_pbyte = r_item.passed_duration[7:0];
            PB_TYPE:    w_pbyte = r_open_type;
            PB_N_HI:    w_pbyte = r_chunk[15:8];
            PB_N_LO:    w_pbyte = r_chunk[7:0];
            default:    w_pbyte = 8'd0;
        endcase
    end

    // Store port steering
    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_addr  = w_cur_base + AW'(r_cur_len);
        w_wdata = w_pbyte;
        case (i_cmd.op)
            OP_SWEEP: begin
                w_we    = 1'b1;
                w_addr  = r_sweep;
                w_wdata = 8'd0;
            end
            OP_PUT: begin
                w_we = w_put_ok;
            end
            OP_REC: begin
                w_we    = w_put_ok;
                w_wdata = r_item.data_byte;
            end
            OP_FINAL: begin
                w_we    = (int'(r_cpos) < FRAGMENT_BYTES);
                w_addr  = AW'(r_cpos);
                w_wdata = 8'(w_total);
            end
            OP_READ: begin
                w_re   = 1'b1;
                w_addr = w_rd_addr;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    rmf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_q)
    );

    rmf_div #(
        .W (DIV_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (DIV_W'(w_room - 16'd3)),
        .i_den   (r_open_size),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Fragment and section state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur          <= '0;
            r_started      <= 1'b0;
            r_cur_len      <= '0;
            r_cur_session  <= '0;
            r_cpos         <= '0;
            r_open_type    <= '0;
            r_open_size    <= '0;
            r_open_session <= '0;
            r_sec          <= '0;
            r_chunk        <= '0;
            r_bytes        <= '0;
            r_sweep        <= '0;
            for (int i = 0; i < FRAGMENT_SLOTS; i++) begin
                r_len_tbl[i] <= '0;
            end
        end else begin
            if (i_cmd.close) begin
                r_sec   <= '0;
                r_chunk <= '0;
                r_bytes <= '0;
            end
            case (i_cmd.op)
                OP_CLEAR: begin
                    r_cur     <= '0;
                    r_started <= 1'b0;
                    r_cur_len <= '0;
                    r_sec     <= '0;
                    r_chunk   <= '0;
                    r_bytes   <= '0;
                    r_sweep   <= '0;
                    for (int i = 0; i < FRAGMENT_SLOTS; i++) begin
                        r_len_tbl[i] <= '0;
                    end
                end
                OP_SWEEP: begin
                    r_sweep <= (r_sweep == AW'(DEPTH - 1)) ? '0 : (r_sweep + 1'b1);
                end
                OP_BEGIN_FRAG: begin
                    r_cur                  <= w_total[CW-1:0];
                    r_started              <= 1'b1;
                    r_cur_len              <= '0;
                    r_len_tbl[w_total[CW-1:0]] <= '0;
                    r_cur_session <= i_cmd.use_item_ses ? r_item.session_id : r_open_session;
                end
                OP_PUT: begin
                    if (w_put_ok) begin
                        r_cur_len        <= r_cur_len + 1'b1;
                        r_len_tbl[r_cur] <= r_cur_len + 1'b1;
                    end
                    if (i_cmd.pb == PB_ZERO) begin
                        r_cpos <= r_cur_len;
                    end
                end
                OP_REC: begin
                    if (w_put_ok) begin
                        r_cur_len        <= r_cur_len + 1'b1;
                        r_len_tbl[r_cur] <= r_cur_len + 1'b1;
                    end
                    if (w_rec_last) begin
                        r_chunk <= r_chunk - 1'b1;
                        r_sec   <= r_sec - 1'b1;
                        r_bytes <= w_chunk_more ? r_open_size : 10'd0;
                    end else begin
                        r_bytes <= r_bytes - 1'b1;
                    end
                end
                OP_OPEN: begin
                    r_open_type    <= r_item.section_type;
                    r_open_size    <= r_item.record_bytes;
                    r_open_session <= r_item.session_id;
                    r_sec          <= r_item.record_total;
                    r_chunk        <= '0;
                    r_bytes        <= '0;
                end
                OP_SET_CHUNK: begin
                    r_chunk <= w_n;
                    r_bytes <= r_open_size;
                end
                default: begin
                    r_sweep <= r_sweep;
                end
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status         <= i_cmd.status;
            r_out.read_data      <= ((r_item.action == ACT_READ) && w_frag_ok && w_off_ok)
                                    ? w_q : 8'd0;
            r_out.read_length    <= ((r_item.action == ACT_READ) && w_frag_ok)
                                    ? 10'(r_len_tbl[w_rd_idx]) : 10'd0;
            r_out.fragment_total <= 5'(w_total);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to the controller
    always_comb begin
        o_stat.action          = r_item.action;
        o_stat.cap_lt4         = (i_capacity < 10'd4);
        o_stat.next_full       = (int'(w_total) >= FRAGMENT_SLOTS);
        o_stat.item_size_zero  = (r_item.record_bytes == 10'd0);
        o_stat.item_cap_short  = (w_cap16 < 16'd7 + 16'(r_item.record_bytes));
        o_stat.item_total_zero = (r_item.record_total == 16'd0);
        o_stat.chunk_cap_fail  = (w_cap16 < 16'd7 + 16'(r_open_size)) || (r_open_size == 10'd0);
        o_stat.started         = r_started;
        o_stat.ses_mismatch    = (r_cur_session != r_open_session);
        o_stat.room_short      = (w_room < 16'd3 + 16'(r_open_size));
        o_stat.chunk_open      = (r_chunk != 16'd0);
        o_stat.rec_last        = w_rec_last;
        o_stat.chunk_more      = w_chunk_more;
        o_stat.sect_more       = (r_sec > 16'd1);
        o_stat.div_busy        = w_div_busy;
        o_stat.sweep_last      = (r_sweep == AW'(DEPTH - 1));
        o_stat.out_full        = r_out_valid && !i_out_ready;
    end

    // Fragment 0 is current until the first fragment begins
    a_idle_cur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_cur == '0))
        else $error("current fragment moved before any fragment began");

    // A fragment never grows past its slot
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_len <= LW'(FRAGMENT_BYTES))
        else $error("fragment length beyond slot size");

    // An open chunk always expects more record bytes
    a_chunk_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chunk != 16'd0) |-> (r_bytes != 10'd0))
        else $error("open chunk with no bytes pending");

    // A chunk is never opened with a record count of zero
    a_div_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_SET_CHUNK) |-> (w_n != 16'd0))
        else $error("empty chunk opened");

endmodule

[rtl/core/record_message_fragmenter.sv]
// Record message fragmenter.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one action per
// transfer: clear, start session, open section, record byte, finalize or
// read. The output channel (o_out_valid / i_out_ready / o_out_data) returns
// exactly one result per action. Fragment capacity is set through the APB
// port at byte address 0 and should only change while the block is idle.
// Items are handled one at a time; every byte appended is a write to
// the single-port fragment store. Opening a chunk runs the bit-serial
// divider to size the chunk, after first beginning a new fragment when
// the current one lacks room; clear sweeps the whole store to zero.
// After reset the store is zeroed by a sweep over all
// FRAGMENT_SLOTS*FRAGMENT_BYTES bytes (8192 by default), during which
// o_in_ready stays low.
// The result sits in an output register; while the receiver stalls the
// block finishes the current item and then holds off the next one.
module record_message_fragmenter (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rmf_pkg::t_item    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rmf_pkg::t_result  o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import rmf_pkg::*;

    logic [CFG_W-1:0] r_capacity;
    logic             w_accept;
    logic             w_cfg_we;
    t_cmd             w_cmd;
    t_dp_stat         w_stat;

    assign w_accept = i_in_valid && o_in_ready;

    // Configuration register, clamped to the slot size
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CFG_W'(20);
        end else if (w_cfg_we) begin
            r_capacity <= (int'(pwdata[CFG_W-1:0]) > FRAGMENT_BYTES)
                          ? CFG_W'(FRAGMENT_BYTES) : pwdata[CFG_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(r_capacity);

    rmf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    rmf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_data),
        .i_capacity  (r_capacity),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data)
    );

endmodule

[test/record_message_fragmenter_tb.sv]
`timescale 1ns / 100ps

module record_message_fragmenter_tb;
    import rmf_pkg::*;

    localparam int SLOTS      = 16;
    localparam int SLOT_BYTES = 512;
    localparam int WD_LIMIT   = 40000;
    localparam int ITEM_W     = $bits(t_item);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_item       i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_result     o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    record_message_fragmenter dut (.*);

    always #5 i_clk = ~i_clk;

    // Mirror of the fragment store and builder state
    logic [7:0] frag_mem [SLOTS*SLOT_BYTES];
    int frag_len [SLOTS];
    int cur_frag, count_pos, cap;
    bit started;
    int sec_type, rec_size, sec_left, chunk_left, byte_left, sec_session;

    t_result pending_results[$];
    int  errors = 0;
    int  items_sent = 0;
    bit  idle_on = 1'b1;
    int  quiet_cycles = 0;
    int  out_stall = 0;
    logic [15:0] cur_sid = 16'h1234;

    function automatic void put_byte(int b);
        if (frag_len[cur_frag] < SLOT_BYTES) begin
            frag_mem[cur_frag*SLOT_BYTES + frag_len[cur_frag]] = b[7:0];
            frag_len[cur_frag]++;
        end
    endfunction

    function automatic void close_sec();
        sec_left = 0;
        chunk_left = 0;
        byte_left = 0;
    endfunction

    function automatic logic [2:0] begin_frag(int ses);
        int nxt;
        if (cap < 4) return ST_CAPACITY;
        nxt = started ? cur_frag + 1 : 0;
        if (nxt >= SLOTS) return ST_NO_SLOT;
        cur_frag = nxt;
        started = 1'b1;
        frag_len[nxt] = 0;
        put_byte(nxt >> 8);
        put_byte(nxt);
        put_byte(ses >> 8);
        put_byte(ses);
        return ST_OK;
    endfunction

    function automatic int room_left();
        return (frag_len[cur_frag] >= cap) ? 0 : cap - frag_len[cur_frag];
    endfunction

    function automatic logic [2:0] begin_chunk();
        int base, room, fit, n;
        logic [2:0] st;
        if (cap < 7 + rec_size || rec_size == 0) return ST_CAPACITY;
        if (!started) return ST_SESSION;
        base = cur_frag*SLOT_BYTES;
        if ({frag_mem[base+2], frag_mem[base+3]} != sec_session[15:0]) return ST_SESSION;
        room = room_left();
        if (room < 3 + rec_size) begin
            st = begin_frag(sec_session);
            if (st != ST_OK) return st;
            room = room_left();
        end
        fit = (room - 3) / rec_size;
        n = (sec_left < fit) ? sec_left : fit;
        put_byte(sec_type);
        put_byte(n >> 8);
        put_byte(n);
        chunk_left = n;
        byte_left = rec_size;
        return ST_OK;
    endfunction

    // Expected result of one action, updating the mirror
    function automatic t_result fragmenter_step(t_item it);
        t_result r;
        int total;
        r = '0;
        case (it.action)
            ACT_CLEAR: begin
                foreach (frag_mem[k]) frag_mem[k] = 8'h00;
                foreach (frag_len[k]) frag_len[k] = 0;
                cur_frag = 0;
                started = 1'b0;
                close_sec();
            end
            ACT_START: begin
                close_sec();
                r.status = begin_frag(it.session_id);
                if (r.status == ST_OK) begin
                    put_byte(REC_COUNT);
                    count_pos = frag_len[cur_frag];
                    put_byte(0);
                    put_byte(REC_DURATION);
                    put_byte(it.total_duration >> 8);
                    put_byte(it.total_duration);
                    put_byte(REC_PASSED);
                    put_byte(it.passed_duration >> 8);
                    put_byte(it.passed_duration);
                end
            end
            ACT_SECTION: begin
                close_sec();
                if (it.record_bytes == 0) r.status = ST_BAD_SIZE;
                else if (cap < 7 + int'(it.record_bytes)) r.status = ST_CAPACITY;
                else if (it.record_total != 0) begin
                    sec_type = it.section_type;
                    rec_size = it.record_bytes;
                    sec_session = it.session_id;
                    sec_left = it.record_total;
                    r.status = begin_chunk();
                    if (r.status != ST_OK) close_sec();
                end
            end
            ACT_RECORD: begin
                if (chunk_left == 0) r.status = ST_NO_SECTION;
                else begin
                    put_byte(it.data_byte);
                    if (byte_left > 0) byte_left--;
                    if (byte_left == 0) begin
                        chunk_left--;
                        sec_left--;
                        if (chunk_left > 0) byte_left = rec_size;
                        else if (sec_left > 0) begin
                            r.status = begin_chunk();
                            if (r.status != ST_OK) close_sec();
                        end else close_sec();
                    end
                end
            end
            ACT_FINALIZE: begin
                total = started ? cur_frag + 1 : 0;
                if (count_pos < SLOT_BYTES) frag_mem[count_pos] = total[7:0];
            end
            ACT_READ: begin
                if (it.read_fragment < SLOTS) begin
                    r.read_length = 10'(frag_len[it.read_fragment]);
                    if (it.read_offset < SLOT_BYTES)
                        r.read_data = frag_mem[it.read_fragment*SLOT_BYTES + it.read_offset];
                end
            end
            default: ;
        endcase
        total = started ? cur_frag + 1 : 0;
        r.fragment_total = total[4:0];
        return r;
    endfunction

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result exp_r;
        if (o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: %h", o_out_data);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_out_data.status !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, o_out_data.status);
                    errors++;
                end
                if (o_out_data.read_data !== exp_r.read_data) begin
                    $error("read_data exp %0d got %0d", exp_r.read_data, o_out_data.read_data);
                    errors++;
                end
                if (o_out_data.read_length !== exp_r.read_length) begin
                    $error("read_length exp %0d got %0d", exp_r.read_length,
                           o_out_data.read_length);
                    errors++;
                end
                if (o_out_data.fragment_total !== exp_r.fragment_total) begin
                    $error("fragment_total exp %0d got %0d", exp_r.fragment_total,
                           o_out_data.fragment_total);
                    errors++;
                end
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= (out_stall == 0);
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall = $urandom_range(1, 3);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_item(t_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(fragmenter_step(it));
        items_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_capacity(int value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'd0;
        pwdata <= value;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cap = (value[9:0] > SLOT_BYTES) ? SLOT_BYTES : value[9:0];
    endtask

    function automatic t_item rand_item(logic [2:0] act);
        t_item it;
        it = ITEM_W'({$urandom, $urandom, $urandom, $urandom});
        it.action = act;
        return it;
    endfunction

    task automatic do_action(logic [2:0] act);
        send_item(rand_item(act));
    endtask

    task automatic do_start(logic [15:0] sid);
        t_item it;
        it = rand_item(ACT_START);
        it.session_id = sid;
        send_item(it);
    endtask

    task automatic do_section(logic [15:0] sid, int sz, int cnt);
        t_item it;
        it = rand_item(ACT_SECTION);
        it.session_id = sid;
        it.record_bytes = 10'(sz);
        it.record_total = 16'(cnt);
        send_item(it);
    endtask

    task automatic do_read(int frag, int off);
        t_item it;
        it = rand_item(ACT_READ);
        it.read_fragment = 5'(frag);
        it.read_offset = 9'(off);
        send_item(it);
    endtask

    task automatic feed_bytes(int n);
        for (int k = 0; k < n; k++) do_action(ACT_RECORD);
    endtask

    task automatic test_directed();
        do_read(0, 0);
        do_read(31, 5);
        do_read(3, 511);
        do_action(ACT_FINALIZE);                // no fragment yet
        do_action(ACT_RECORD);                  // no open section
        do_section(16'h00AA, 3, 2);             // nothing started
        do_start(16'h00AA);
        do_section(16'h00AA, 0, 4);             // zero record size
        do_section(16'h00AA, 14, 1);            // capacity short
        do_section(16'h00AA, 2, 0);             // empty section
        do_section(16'h00AB, 2, 1);             // session mismatch
        do_section(16'h00AA, 2, 3);             // spans chunks and fragments
        feed_bytes(6);
        do_action(3'd6);
        do_action(3'd7);
        do_action(ACT_FINALIZE);
        do_read(0, 5);
        do_read(1, 0);
        write_capacity(3);
        do_start(16'h0001);                     // capacity below header
        write_capacity(1023);                   // clamped
        do_start(16'hFFFF);
        do_section(16'hFFFF, 505, 1);
        do_section(16'hFFFF, 4, 3);             // reopen abandons the first
        feed_bytes(5);
    endtask

    // Sessions and sections until the slots run out
    task automatic test_slot_exhaustion();
        write_capacity(20);
        for (int k = 0; k < 17; k++) do_start(16'(16'h0C00 + k));
        do_section(16'h0C0F, 5, 4);
        feed_bytes(6);
        do_action(ACT_FINALIZE);
        do_read(15, 0);
        do_action(ACT_CLEAR);
        do_read(2, 1);
    endtask

    task automatic random_phase(int cap_value, int n_items);
        int stop_at, sz, cnt, r;
        write_capacity(cap_value);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if (started && cur_frag >= 14 && $urandom_range(0, 2) == 0) do_action(ACT_CLEAR);
            r = $urandom_range(0, 99);
            if (r < 8) do_action(3'($urandom_range(2, 7)));
            else if (r < 20) do_read($urandom_range(0, 31), $urandom_range(0, 511));
            else if (r < 25) do_action(ACT_FINALIZE);
            else if (r < 35) begin
                if ($urandom_range(0, 1)) cur_sid = 16'($urandom);
                do_start(cur_sid);
            end else begin
                sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(1, 6);
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(1, 6);
                do_section(($urandom_range(0, 9) == 0) ? 16'($urandom) : cur_sid, sz, cnt);
                if (sz <= 6 && cnt <= 6)
                    feed_bytes(sz*cnt - (($urandom_range(0, 9) == 0) ? 1 : 0));
            end
        end
    endtask

    task automatic test_random();
        random_phase(20, 70);
        random_phase(7, 40);
        random_phase(512, 60);
        drain();                                // sender holds until all results are in
        random_phase(11, 60);
        random_phase(4, 30);
        random_phase(33, 60);
    endtask

    task automatic test_no_idle();
        idle_on = 1'b0;
        random_phase(20, 60);
    endtask

    initial begin
        foreach (frag_mem[k]) frag_mem[k] = 8'h00;
        foreach (frag_len[k]) frag_len[k] = 0;
        cur_frag = 0;
        count_pos = 0;
        cap = 20;
        started = 1'b0;
        sec_type = 0;
        rec_size = 0;
        sec_session = 0;
        close_sec();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_slot_exhaustion();
        test_random();
        test_no_idle();
        drain();
        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
